[hw/rtl/uf_pkg.sv]
// ----------------------------------------------------------------------------
// uf_pkg
// Shared types and codes for the disjoint-set (union-find) engine.
// ----------------------------------------------------------------------------
package uf_pkg;

  // Element fields on the stream ports.
  localparam int ELEM_W = 4;

  // Per-entry rank, saturating.
  localparam int        RANK_W   = 3;
  localparam logic [2:0] RANK_MAX = 3'd7;

  // Operation codes carried in s_tuser.
  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_UNION = 1'b1;

  // Link policy register values.
  localparam logic MODE_PLAIN = 1'b0;
  localparam logic MODE_RANK  = 1'b1;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic [ELEM_W-1:0] root;
    logic              merged;
  } uf_result_t;

endpackage

[hw/rtl/uf_ram.sv]
// ----------------------------------------------------------------------------
// uf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/uf_ctrl.sv]
// ----------------------------------------------------------------------------
// uf_ctrl
// Sequencer for the union-find engine: clears the forest after reset, walks
// parent links one memory read a cycle and writes back the link and rank.
// ----------------------------------------------------------------------------
module uf_ctrl
  import uf_pkg::*;
#(
  parameter int NUM_ELEMENTS = 16,
  localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             union_mode,
  input  logic             start,
  input  logic             op,
  input  logic [IDX_W-1:0] elem_a,
  input  logic [IDX_W-1:0] elem_b,
  output logic             ready,
  output logic             res_valid,
  input  logic             res_ready,
  output uf_result_t       res
);

  localparam int ENT_W = RANK_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_ELEMENTS - 1);
  localparam logic [IDX_W:0]   WALK_MAX  = (IDX_W + 1)'(NUM_ELEMENTS);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK_A = 3'd2;
  localparam logic [2:0] ST_WALK_B = 3'd3;
  localparam logic [2:0] ST_RAISE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  clr_cnt, clr_cnt_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [IDX_W:0]    steps, steps_next;
  logic              op_q, op_q_next;
  logic [IDX_W-1:0]  b_q, b_q_next;
  logic [IDX_W-1:0]  root_a, root_a_next;
  logic [RANK_W-1:0] rank_a, rank_a_next;
  logic [IDX_W-1:0]  res_idx, res_idx_next;
  logic              res_merged, res_merged_next;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  logic [IDX_W-1:0]  rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic              walk_done;
  logic [IDX_W+ELEM_W-1:0] res_ext;

  // One entry holds {rank, parent}.
  uf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_ELEMENTS)
  ) u_forest (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_parent = mem_rdata[IDX_W-1:0];
  assign rd_rank   = mem_rdata[ENT_W-1:IDX_W];
  assign walk_done = (rd_parent == cur) || (steps == WALK_MAX);

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    cur_next        = cur;
    steps_next      = steps;
    op_q_next       = op_q;
    b_q_next        = b_q;
    root_a_next     = root_a;
    rank_a_next     = rank_a;
    res_idx_next    = res_idx;
    res_merged_next = res_merged;
    mem_we          = 1'b0;
    mem_waddr       = cur;
    mem_wdata       = '0;
    mem_raddr       = cur;

    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = {{RANK_W{1'b0}}, clr_cnt};
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_q_next  = op;
          b_q_next   = elem_b;
          cur_next   = elem_a;
          steps_next = '0;
          mem_raddr  = elem_a;
          state_next = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (walk_done) begin
          root_a_next = cur;
          rank_a_next = rd_rank;
          if (op_q == OP_FIND) begin
            res_idx_next    = cur;
            res_merged_next = 1'b0;
            state_next      = ST_FINISH;
          end else begin
            cur_next   = b_q;
            steps_next = '0;
            mem_raddr  = b_q;
            state_next = ST_WALK_B;
          end
        end else begin
          cur_next   = rd_parent;
          steps_next = steps + 1'b1;
          mem_raddr  = rd_parent;
        end
      end
      ST_WALK_B: begin
        if (!walk_done) begin
          cur_next   = rd_parent;
          steps_next = steps + 1'b1;
          mem_raddr  = rd_parent;
        end else if (root_a == cur) begin
          // Same set: leave the forest alone.
          res_idx_next    = root_a;
          res_merged_next = 1'b0;
          state_next      = ST_FINISH;
        end else begin
          res_merged_next = 1'b1;
          state_next      = ST_FINISH;
          if (union_mode == MODE_PLAIN || rank_a <= rd_rank) begin
            // First root goes under the second.
            mem_we       = 1'b1;
            mem_waddr    = root_a;
            mem_wdata    = {rank_a, cur};
            res_idx_next = cur;
            if (union_mode == MODE_RANK && rank_a == rd_rank && rd_rank != RANK_MAX) begin
              rank_a_next = rd_rank + 1'b1;
              state_next  = ST_RAISE;
            end
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = cur;
            mem_wdata    = {rd_rank, root_a};
            res_idx_next = root_a;
          end
        end
      end
      ST_RAISE: begin
        // Second root stays a root, one rank higher.
        mem_we     = 1'b1;
        mem_waddr  = cur;
        mem_wdata  = {rank_a, cur};
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
    cur        <= cur_next;
    steps      <= steps_next;
    op_q       <= op_q_next;
    b_q        <= b_q_next;
    root_a     <= root_a_next;
    rank_a     <= rank_a_next;
    res_idx    <= res_idx_next;
    res_merged <= res_merged_next;
  end

  assign ready      = (state == ST_IDLE);
  assign res_valid  = (state == ST_FINISH);
  assign res_ext    = {{ELEM_W{1'b0}}, res_idx};
  assign res.root   = res_ext[ELEM_W-1:0];
  assign res.merged = res_merged;

endmodule

[hw/rtl/union_find_engine_top.sv]
// ----------------------------------------------------------------------------
// union_find_engine_top
// Disjoint-set engine with find and union (plain or by rank) over a memory forest.
// ----------------------------------------------------------------------------
// Usage
//   Input items arrive on s_t*: s_tuser is the operation (find or union),
//   s_tdata carries the two element indices. Each item gives exactly one
//   result item on m_t*: m_tdata holds the root, m_tuser the merged flag.
//   Indices at or above NUM_ELEMENTS wrap modulo NUM_ELEMENTS.
//   The cfg_* channel writes the link policy (0 plain, 1 by rank); write it
//   only while no item is in flight. cfg_ready is always high.
// Walk
//   The forest lives in one RAM and the walk follows one parent link per
//   read. A find walks the chain of its element; a union walks both chains
//   and then links the two roots, raising a rank where the policy needs it.
//   A chain has at most NUM_ELEMENTS - 1 links. One item is in the engine
//   at a time.
// Reset
//   After rst the RAM is swept, one entry a cycle, over all NUM_ELEMENTS
//   entries; s_tready stays low during the sweep. Each element then is its own root.
// Stall
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its result holds in the engine until the register frees.
// ----------------------------------------------------------------------------
module union_find_engine_top
  import uf_pkg::*;
#(
  parameter int NUM_ELEMENTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  // config write channel: bit 0 union_mode
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_data,
  // input items
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] elem_a, [7:4] elem_b
  input  logic [0:0] s_tuser,   // [0] opcode
  // result items
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] root, [7:4] zero
  output logic [0:0] m_tuser    // [0] merged
);

  localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam logic [12:0] NUM_E = 13'(NUM_ELEMENTS);

  logic             union_mode;
  logic             start;
  logic             eng_ready;
  logic             res_valid;
  logic             res_ready;
  uf_result_t       res;
  logic [IDX_W-1:0] idx_a;
  logic [IDX_W-1:0] idx_b;
  logic [12:0]      wrap_a;
  logic [12:0]      wrap_b;
  logic [ELEM_W-1:0] m_root;
  logic             m_merged;

  // Wrap indices into range: eight subtractions cover a 4-bit value when NUM_ELEMENTS is at least 2.
  always_comb begin
    wrap_a = {9'd0, s_tdata[3:0]};
    wrap_b = {9'd0, s_tdata[7:4]};
    for (int i = 0; i < 8; i++) begin
      if (wrap_a >= NUM_E) begin
        wrap_a = wrap_a - NUM_E;
      end
      if (wrap_b >= NUM_E) begin
        wrap_b = wrap_b - NUM_E;
      end
    end
  end

  assign idx_a = wrap_a[IDX_W-1:0];
  assign idx_b = wrap_b[IDX_W-1:0];

  // Link policy register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      union_mode <= MODE_RANK;
    end else if (cfg_valid) begin
      union_mode <= cfg_data[0];
    end
  end

  assign s_tready = eng_ready;
  assign start    = s_tvalid && eng_ready;

  uf_ctrl #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .union_mode (union_mode),
    .start      (start),
    .op         (s_tuser[0]),
    .elem_a     (idx_a),
    .elem_b     (idx_b),
    .ready      (eng_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: load when empty or being drained, drop on take.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      m_root   <= res.root;
      m_merged <= res.merged;
    end
  end

  assign m_tdata = {4'b0000, m_root};
  assign m_tuser = m_merged;

endmodule

[hw/rtl/uf_checker.sv]
// ----------------------------------------------------------------------------
// uf_checker
// Port-level checks on the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
module uf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser
);

  // Hold a stalled result unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // The clearing sweep follows reset: no item is taken straight after it.
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("item taken during clearing sweep");

  // One item at a time: ready drops after an accepted item.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while walking");

  // Pad bits above the root stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'b0000)
    else $error("result pad bits set");

endmodule

bind union_find_engine_top uf_checker u_uf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
